// ----- src/sam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_pkg
// Types, codes and defaults shared by the stack allocator block.
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int MARKER_BYTES_DEF = 16;

    localparam int ADDR_W   = 48;
    localparam int BYTES_W  = 32;
    localparam int ALIGN_W  = 8;
    localparam int MARKER_W = 9;
    localparam int CFG_IDX_W = 1;

    // request codes
    localparam logic [1:0] CMD_ALLOC     = 2'd0;
    localparam logic [1:0] CMD_FREE_TO   = 2'd1;
    localparam logic [1:0] CMD_FREE_LAST = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_ABOVE    = 2'd2;
    localparam logic [1:0] ST_NOT_LAST = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd1;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [BYTES_W-1:0]  request_bytes;
        logic [ALIGN_W-1:0]  align_bytes;
        logic [MARKER_W-1:0] marker_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ADDR_W-1:0]   block_address;
        logic [MARKER_W-1:0] new_marker;
        logic [BYTES_W-1:0]  used_after;
        logic                is_empty;
    } out_item_t;

endpackage

// ----- src/stack_allocator_with_markers_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_allocator_with_markers_top
// Linear stack allocator with marker-based free, built around one shared
// 48-bit adder stepped by a small sequencer.
// ----------------------------------------------------------------------------
// One request is in flight at a time; s_ready is high only while idle. An
// allocate runs seven adder steps: remaining capacity, size, marker
// overhead, fit compare, base add, align round-up, commit. A failed
// allocate stops after the fit compare; a free that pops to an earlier
// marker passes through a state that waits on the offset memory read; clear
// or a rejected/total free goes straight to the result. The result is held
// on m_item until taken. The offset memory has no reset; only entries below
// the current top are ever read. Configuration may be written at any time
// the block is idle and takes effect on the next request.
// ----------------------------------------------------------------------------
module stack_allocator_with_markers_top #(
    parameter int MAX_BLOCKS   = sam_pkg::MAX_BLOCKS_DEF,
    parameter int MARKER_BYTES = sam_pkg::MARKER_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sam_pkg::in_item_t                   s_item,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output sam_pkg::out_item_t                  m_item,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sam_pkg::ADDR_W-1:0]          cfg_data
);
    import sam_pkg::*;

    localparam int AW          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int DEPTH_LIMIT = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;
    localparam int BLK_W       = BYTES_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_A_SUM,
        S_A_BLK,
        S_A_FIT,
        S_A_BASE,
        S_A_ALIGN,
        S_A_COMMIT,
        S_POP,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           cmd_reg;
    logic [BYTES_W-1:0]   req_reg;
    logic [ALIGN_W-1:0]   align_reg;
    logic [MARKER_W-1:0]  mid_reg;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [BYTES_W-1:0]   cap_reg, cap_next;
    logic [BYTES_W-1:0]   used_reg, used_next;
    logic [MARKER_W-1:0]  top_reg, top_next;
    logic [BYTES_W-1:0]   remain_reg, remain_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    out_item_t            res_reg, res_next;

    // offset memory: used_bytes seen before each push
    logic [BYTES_W-1:0]   offs_mem [MAX_BLOCKS];
    logic [BYTES_W-1:0]   rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        wr_idx;
    logic [AW-1:0]        rd_idx;

    // shared adder
    logic [ADDR_W-1:0]    add_a, add_b;
    logic                 add_cin;
    logic [ADDR_W:0]      add_sum;

    logic                 align_pow2;
    logic [ALIGN_W-1:0]   align_m1;
    logic                 depth_full;
    logic [MARKER_W-1:0]  top_inc;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign m_item    = res_reg;
    assign cfg_ready = 1'b1;

    assign align_pow2 = (align_reg != '0) && ((align_reg & (align_reg - 8'd1)) == '0);
    assign align_m1   = align_pow2 ? (align_reg - 8'd1) : '0;
    assign depth_full = (top_reg >= MARKER_W'(DEPTH_LIMIT));
    assign top_inc    = top_reg + 9'd1;

    assign wr_idx = AW'(top_reg);
    assign rd_idx = AW'(mid_reg - 9'd1);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_DEC: begin
                // capacity - used, carry out set when it does not go negative
                add_a   = {16'd0, cap_reg};
                add_b   = {16'hFFFF, ~used_reg};
                add_cin = 1'b1;
            end
            S_A_SUM: begin
                add_a = {16'd0, req_reg};
                add_b = {40'd0, align_reg};
            end
            S_A_BLK: begin
                add_a = {14'd0, blk_reg};
                add_b = ADDR_W'(MARKER_BYTES);
            end
            S_A_FIT: begin
                add_a   = {16'd0, remain_reg};
                add_b   = ~{14'd0, blk_reg};
                add_cin = 1'b1;
            end
            S_A_BASE: begin
                add_a = base_reg;
                add_b = {16'd0, used_reg};
            end
            S_A_ALIGN: begin
                add_a = addr_reg;
                add_b = {40'd0, align_m1};
            end
            S_A_COMMIT: begin
                add_a = {16'd0, used_reg};
                add_b = {14'd0, blk_reg};
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{ADDR_W{1'b0}}, add_cin};
    end

    always_comb begin
        state_next  = state_reg;
        base_next   = base_reg;
        cap_next    = cap_reg;
        used_next   = used_reg;
        top_next    = top_reg;
        remain_next = remain_reg;
        blk_next    = blk_reg;
        addr_next   = addr_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                REG_BASE_ADDR: base_next = cfg_data;
                REG_CAPACITY:  cap_next  = cfg_data[BYTES_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DEC;
            end
            S_DEC: begin
                res_next               = '0;
                res_next.status        = ST_OK;
                res_next.used_after    = used_reg;
                res_next.is_empty      = (used_reg == '0);
                remain_next = add_sum[ADDR_W] ? add_sum[BYTES_W-1:0] : '0;
                case (cmd_reg)
                    CMD_ALLOC: begin
                        state_next = S_A_SUM;
                    end
                    CMD_FREE_TO, CMD_FREE_LAST: begin
                        if (cmd_reg == CMD_FREE_TO && mid_reg > top_reg) begin
                            res_next.status = ST_ABOVE;
                            state_next      = S_OUT;
                        end else if (cmd_reg == CMD_FREE_LAST && mid_reg != top_reg) begin
                            res_next.status = ST_NOT_LAST;
                            state_next      = S_OUT;
                        end else if (mid_reg == '0) begin
                            used_next           = '0;
                            top_next            = '0;
                            res_next.used_after = '0;
                            res_next.is_empty   = 1'b1;
                            state_next          = S_OUT;
                        end else begin
                            mem_re     = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    default: begin
                        used_next           = '0;
                        top_next            = '0;
                        res_next.used_after = '0;
                        res_next.is_empty   = 1'b1;
                        state_next          = S_OUT;
                    end
                endcase
            end
            S_A_SUM: begin
                blk_next   = add_sum[BLK_W-1:0];
                state_next = S_A_BLK;
            end
            S_A_BLK: begin
                blk_next   = add_sum[BLK_W-1:0];
                state_next = S_A_FIT;
            end
            S_A_FIT: begin
                if (!add_sum[ADDR_W] || depth_full) begin
                    res_next.status = ST_OOM;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_A_BASE;
                end
            end
            S_A_BASE: begin
                addr_next  = add_sum[ADDR_W-1:0];
                state_next = S_A_ALIGN;
            end
            S_A_ALIGN: begin
                addr_next  = add_sum[ADDR_W-1:0] & ~{40'd0, align_m1};
                state_next = S_A_COMMIT;
            end
            S_A_COMMIT: begin
                mem_we                 = 1'b1;
                used_next              = add_sum[BYTES_W-1:0];
                top_next               = top_inc;
                res_next.status        = ST_OK;
                res_next.block_address = addr_reg;
                res_next.new_marker    = top_inc;
                res_next.used_after    = add_sum[BYTES_W-1:0];
                res_next.is_empty      = (add_sum[BYTES_W-1:0] == '0);
                state_next             = S_OUT;
            end
            S_POP: begin
                used_next           = rd_data_reg;
                top_next            = mid_reg - 9'd1;
                res_next.used_after = rd_data_reg;
                res_next.is_empty   = (rd_data_reg == '0);
                state_next          = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            cap_reg   <= '0;
            used_reg  <= '0;
            top_reg   <= '0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            cap_reg   <= cap_next;
            used_reg  <= used_next;
            top_reg   <= top_next;
        end
        if (s_valid && s_ready) begin
            cmd_reg   <= s_item.cmd;
            req_reg   <= s_item.request_bytes;
            align_reg <= s_item.align_bytes;
            mid_reg   <= s_item.marker_id;
        end
        remain_reg <= remain_next;
        blk_reg    <= blk_next;
        addr_reg   <= addr_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            offs_mem[wr_idx] <= used_reg;
        end
        if (mem_re) begin
            rd_data_reg <= offs_mem[rd_idx];
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= MARKER_W'(DEPTH_LIMIT))
        else $error("marker depth beyond limit");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result shown in the cycle after accept");

    a_alloc_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && cmd_reg == CMD_ALLOC && res_reg.status == ST_OK
        |-> res_reg.new_marker == top_reg && top_reg != '0)
        else $error("allocate marker does not match depth");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_reg.status != ST_OK
        |-> res_reg.block_address == '0 && res_reg.new_marker == '0)
        else $error("failed request carries an address or marker");

    a_result_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> res_reg.used_after == used_reg
                 && res_reg.is_empty == (used_reg == '0))
        else $error("result usage disagrees with state");

endmodule

// ----- bench/tb_stack_allocator_with_markers_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_allocator_with_markers_top
// Self-checking bench for the marker-based stack allocator. A shadow of the
// allocator state predicts each result from the accepted request and the
// current base/capacity registers. Results are compared field by field in
// order. Stimulus is a directed pass over the corner cases, then random
// request mixes under several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_stack_allocator_with_markers_top;

    import sam_pkg::*;

    // shadow of the allocator: registers, used bytes, marker stack
    class stack_shadow;
        localparam int DEPTH_CAP = (MAX_BLOCKS_DEF < 511) ? MAX_BLOCKS_DEF : 511;

        logic [ADDR_W-1:0]  base_addr;
        logic [BYTES_W-1:0] capacity;
        logic [BYTES_W-1:0] used;
        int unsigned        depth;
        logic [BYTES_W-1:0] start_offset [MAX_BLOCKS_DEF];
        out_item_t          pending_results [$];
        int unsigned        errors;
        int unsigned        max_depth;
        int unsigned        cmd_count [4];
        int unsigned        status_count [4];

        function new();
            base_addr = '0;
            capacity  = '0;
            used      = '0;
            depth     = 0;
            errors    = 0;
            max_depth = 0;
            foreach (cmd_count[i]) cmd_count[i] = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
            if (idx == REG_BASE_ADDR) begin
                base_addr = data;
            end else begin
                capacity = data[BYTES_W-1:0];
            end
        endfunction

        // callers guarantee m <= depth
        function void pop_to(int unsigned m);
            if (m == 0) begin
                used  = '0;
                depth = 0;
            end else begin
                used  = start_offset[m-1];
                depth = m - 1;
            end
        endfunction

        function void note_request(in_item_t req);
            out_item_t         res;
            logic [63:0]       room;
            logic [63:0]       blk;
            logic [ADDR_W-1:0] addr;
            logic [ADDR_W-1:0] amask;
            logic [ALIGN_W-1:0] al;
            res = '0;
            al  = req.align_bytes;
            res.status = ST_OK;
            case (req.cmd)
                CMD_ALLOC: begin
                    room = (capacity > used) ? 64'(capacity - used) : 64'd0;
                    blk  = 64'(req.request_bytes) + 64'(al) + 64'(MARKER_BYTES_DEF);
                    if (blk > room || depth >= DEPTH_CAP) begin
                        res.status = ST_OOM;
                    end else begin
                        addr = base_addr + ADDR_W'(used);
                        // non power-of-two alignment is ignored
                        if (al != 0 && (al & (al - 1'b1)) == 0) begin
                            amask = ADDR_W'(al) - 1'b1;
                            addr  = (addr + amask) & ~amask;
                        end
                        res.block_address = addr;
                        start_offset[depth] = used;
                        used  = used + blk[BYTES_W-1:0];
                        depth = depth + 1;
                        res.new_marker = MARKER_W'(depth);
                    end
                end
                CMD_FREE_TO: begin
                    if (req.marker_id > depth) begin
                        res.status = ST_ABOVE;
                    end else begin
                        pop_to(req.marker_id);
                    end
                end
                CMD_FREE_LAST: begin
                    if (req.marker_id != depth) begin
                        res.status = ST_NOT_LAST;
                    end else begin
                        pop_to(req.marker_id);
                    end
                end
                default: begin
                    used  = '0;
                    depth = 0;
                end
            endcase
            res.used_after = used;
            res.is_empty   = (used == 0);
            if (depth > max_depth) max_depth = depth;
            cmd_count[req.cmd]++;
            status_count[res.status]++;
            pending_results.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                report("unexpected item", 64'(got), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.block_address != want.block_address)
                report("block_address", 64'(got.block_address), 64'(want.block_address));
            if (got.new_marker != want.new_marker)
                report("new_marker", 64'(got.new_marker), 64'(want.new_marker));
            if (got.used_after != want.used_after)
                report("used_after", 64'(got.used_after), 64'(want.used_after));
            if (got.is_empty != want.is_empty)
                report("is_empty", 64'(got.is_empty), 64'(want.is_empty));
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 57;

    stack_shadow shadow = new();

    stack_allocator_with_markers_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // result side: values read here are the ones from before the edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            shadow.check_result(m_item);
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #(1_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic in_item_t make_req(logic [1:0] cmd, logic [BYTES_W-1:0] nbytes,
                                          logic [ALIGN_W-1:0] align,
                                          logic [MARKER_W-1:0] marker);
        in_item_t r;
        r.cmd           = cmd;
        r.request_bytes = nbytes;
        r.align_bytes   = align;
        r.marker_id     = marker;
        return r;
    endfunction

    // mostly well-formed requests against the current stack, some noise
    function automatic in_item_t random_request();
        in_item_t    r;
        int unsigned pick;
        int unsigned sz;
        pick = $urandom_range(0, 99);
        sz   = $urandom_range(0, 9);
        r.request_bytes = (sz < 7) ? $urandom_range(0, 255) :
                          (sz < 9) ? $urandom_range(0, 65535) : $urandom;
        if ($urandom_range(0, 4) == 0) begin
            r.align_bytes = 8'($urandom);
        end else begin
            r.align_bytes = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'(1 << $urandom_range(0, 7));
        end
        r.marker_id = 9'($urandom);
        if (pick < 5) begin
            r.cmd = 2'($urandom);
        end else if (pick < 60) begin
            r.cmd = CMD_ALLOC;
        end else if (pick < 78) begin
            r.cmd = CMD_FREE_TO;
            if ($urandom_range(0, 3) != 0) r.marker_id = 9'($urandom_range(0, shadow.depth));
        end else if (pick < 95) begin
            r.cmd = CMD_FREE_LAST;
            if ($urandom_range(0, 3) != 0) r.marker_id = 9'(shadow.depth);
        end else begin
            r.cmd = CMD_CLEAR;
        end
        return r;
    endfunction

    task automatic push_request(input in_item_t req);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_request(req);
    endtask

    // hold off new requests until every expected result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shadow.pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow.set_register(idx, data);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] cap_word);
        write_register(REG_BASE_ADDR, base);
        write_register(REG_CAPACITY, cap_word);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: base near the top of the address space, full capacity
        configure(48'hFFFF_FFFF_FFF0, 48'h0000_FFFF_FFFF);
        push_request(make_req(CMD_ALLOC, 0, 0, 0));
        push_request(make_req(CMD_ALLOC, 100, 64, 0));       // address wraps to zero
        push_request(make_req(CMD_ALLOC, 5, 3, 0));          // odd alignment ignored
        push_request(make_req(CMD_ALLOC, 7, 128, 0));
        push_request(make_req(CMD_ALLOC, 1, 255, 9'h1FF));
        push_request(make_req(CMD_FREE_LAST, 0, 0, 2));      // not the last marker
        push_request(make_req(CMD_FREE_LAST, 0, 0, 5));
        push_request(make_req(CMD_FREE_TO, 0, 0, 300));      // above top
        push_request(make_req(CMD_FREE_TO, 0, 0, 9'h1FF));
        push_request(make_req(CMD_FREE_TO, 0, 0, 2));
        push_request(make_req(CMD_ALLOC, 32'hFFFF_FFFF, 128, 0));
        push_request(make_req(CMD_ALLOC, shadow.capacity - shadow.used - 16, 0, 0));
        push_request(make_req(CMD_ALLOC, 0, 0, 0));          // region exactly full
        push_request(make_req(CMD_FREE_LAST, 0, 0, 0));
        push_request(make_req(CMD_FREE_TO, 0, 0, 0));
        push_request(make_req(CMD_FREE_LAST, 0, 0, 0));      // empty stack, marker zero
        push_request(make_req(CMD_ALLOC, 200, 16, 0));
        push_request(make_req(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF, 9'h1FF));
        push_request(make_req(CMD_ALLOC, 1, 1, 0));
        push_request(make_req(CMD_FREE_LAST, 0, 0, 1));
        drain();

        // small region: out of memory is frequent
        configure(ADDR_W'({$urandom, $urandom}), 48'd4096);
        repeat (75) push_request(random_request());
        drain();
        repeat (75) push_request(random_request());
        drain();

        send_idle_pct = 57;
        recv_idle_pct = 27;

        // fill the marker stack past its limit, then mix
        configure(48'd0, 48'h0000_FFFF_FFFF);
        push_request(make_req(CMD_CLEAR, 0, 0, 0));
        repeat (262) begin
            push_request(make_req(CMD_ALLOC, $urandom_range(0, 15),
                                  ($urandom_range(0, 5) == 0) ? 8'd0 :
                                  8'(1 << $urandom_range(0, 4)), 0));
        end
        repeat (40) push_request(random_request());
        push_request(make_req(CMD_FREE_TO, 0, 0, (shadow.depth > 1) ? 9'd2 : 9'd0));
        push_request(make_req(CMD_ALLOC, 5000, 0, 0));
        drain();

        // capacity lowered below the bytes in use; upper data bits are ignored
        configure(48'hFFFF_FFFF_FFFF, {16'($urandom), shadow.used >> 1});
        repeat (100) push_request(random_request());
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        configure(ADDR_W'({$urandom, $urandom}), 48'd0);
        repeat (30) push_request(random_request());
        drain();

        configure(ADDR_W'({$urandom, $urandom}), 48'($urandom));
        repeat (230) push_request(random_request());
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d alloc, %0d free-to, %0d free-if-last, %0d clear; deepest stack %0d",
                 shadow.cmd_count[CMD_ALLOC], shadow.cmd_count[CMD_FREE_TO],
                 shadow.cmd_count[CMD_FREE_LAST], shadow.cmd_count[CMD_CLEAR],
                 shadow.max_depth);
        $display("outcomes: %0d ok, %0d out of memory, %0d above top, %0d not last; %0d errors",
                 shadow.status_count[ST_OK], shadow.status_count[ST_OOM],
                 shadow.status_count[ST_ABOVE], shadow.status_count[ST_NOT_LAST],
                 shadow.errors);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
